FILE: sv/lfu_page_replacement_top_assert.svh
// assertion macros shared by the lfu replacement rtl
`ifndef LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH
`define LFU_PAGE_REPLACEMENT_TOP_ASSERT_SVH

// clocked check, quiet while reset is high
`define LFU_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds through reset
`define LFU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: sv/lfu_pkg.sv
// shared constants for the lfu page replacement block
`default_nettype none

package lfu_pkg;

  localparam int NUM_FRAMES_DEF = 8;
  localparam int PAGE_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam int PAGE_FIELD_BITS  = 16;
  localparam int INDEX_FIELD_BITS = 3;
  localparam int FAULT_BITS       = 16;
  localparam int ACTIVE_BITS      = 4;

  localparam logic [ACTIVE_BITS-1:0] ACTIVE_RESET = 4'd8;

endpackage

`default_nettype wire

FILE: sv/lfu_cell.sv
// one frame of the lfu chain: tag, use count and one stage of the search token
`default_nettype none

module lfu_cell #(
  parameter int  NUM_FRAMES = lfu_pkg::NUM_FRAMES_DEF,
  parameter int  PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int  COUNT_BITS = lfu_pkg::COUNT_BITS_DEF,
  parameter int  IDX_BITS   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1,
  parameter int  CELL_INDEX = 0,
  parameter type tok_t      = logic,
  parameter type upd_t      = logic
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic live,
  input  wire tok_t tok_in,
  output tok_t      tok_out,
  input  wire upd_t upd
);

  localparam logic [IDX_BITS-1:0] MY_IDX = IDX_BITS'(CELL_INDEX);

  logic [PAGE_BITS-1:0]  page;
  logic                  valid;
  logic [COUNT_BITS-1:0] count;

  tok_t tok_next;
  logic match;
  logic upd_here;

  assign match    = valid && (page == tok_in.page);
  assign upd_here = upd.en && (upd.idx == MY_IDX);

  always_comb begin
    tok_next = tok_in;
    if (live) begin
      // first match down the chain is the lowest index
      if (!tok_in.found && match) begin
        tok_next.found   = 1'b1;
        tok_next.hit_idx = MY_IDX;
      end
      // strict less keeps the lowest index on ties
      if (!tok_in.best_ok || (count < tok_in.best_cnt)) begin
        tok_next.best_ok     = 1'b1;
        tok_next.best_cnt    = count;
        tok_next.best_idx    = MY_IDX;
        tok_next.best_fvalid = valid;
        tok_next.best_page   = page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      count <= '0;
    end else if (upd_here) begin
      if (upd.hit) begin
        if (count != {COUNT_BITS{1'b1}}) begin
          count <= count + COUNT_BITS'(1);
        end
      end else begin
        valid <= 1'b1;
        count <= COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (upd_here && !upd.hit) begin
      page <= upd.page;
    end
  end

endmodule

`default_nettype wire

FILE: sv/lfu_page_replacement_top.sv
// top level of the lfu page replacement block: control, result register, frame chain
`default_nettype none

// LFU page replacement over a chain of NUM_FRAMES frame cells. Each accepted page
// reference sends a search token down the chain, one cell per cycle, gathering the
// lowest-index tag match and the lowest-count victim; the resolved hit or fault is
// then written back into the chosen cell and the result beat is registered. An item
// occupies the block while the token walks the chain, while it is parked for capture
// and while it is written back; no new reference is taken until that write-back. A
// previous result stalled at the output holds off the write-back, but a waiting
// result does not block the next reference. active_frames is taken through
// cfg_valid/cfg_ready while idle; 0 acts as 1 and values above NUM_FRAMES act as
// NUM_FRAMES.
module lfu_page_replacement_top #(
  parameter int NUM_FRAMES = lfu_pkg::NUM_FRAMES_DEF,
  parameter int PAGE_BITS  = lfu_pkg::PAGE_BITS_DEF,
  parameter int COUNT_BITS = lfu_pkg::COUNT_BITS_DEF
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 cfg_valid,
  output logic                                      cfg_ready,
  input  wire logic [lfu_pkg::ACTIVE_BITS-1:0]      active_frames,
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic [lfu_pkg::PAGE_FIELD_BITS-1:0]  page_number,
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic                                      hit,
  output logic [lfu_pkg::INDEX_FIELD_BITS-1:0]      frame_index,
  output logic                                      evicted_valid,
  output logic [lfu_pkg::PAGE_FIELD_BITS-1:0]       evicted_page,
  output logic [lfu_pkg::FAULT_BITS-1:0]            fault_total
);

  localparam int IDX_BITS = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FB       = lfu_pkg::FAULT_BITS;

  localparam logic [1:0] ST_IDLE    = 2'd0;
  localparam logic [1:0] ST_SEARCH  = 2'd1;
  localparam logic [1:0] ST_RESOLVE = 2'd2;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
    logic                  found;
    logic [IDX_BITS-1:0]   hit_idx;
    logic                  best_ok;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [IDX_BITS-1:0]   best_idx;
    logic                  best_fvalid;
    logic [PAGE_BITS-1:0]  best_page;
  } tok_t;

  typedef struct packed {
    logic                 en;
    logic                 hit;
    logic [IDX_BITS-1:0]  idx;
    logic [PAGE_BITS-1:0] page;
  } upd_t;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [lfu_pkg::ACTIVE_BITS-1:0] active_reg;
  logic [FB-1:0] fault;
  logic [FB-1:0] fault_next;

  tok_t chain [NUM_FRAMES+1];
  tok_t pend;
  upd_t upd;

  logic [NUM_FRAMES-1:0] live;
  logic [NUM_FRAMES-1:0] tok_vld;

  logic accept;
  logic out_free;
  logic resolve;
  logic [IDX_BITS-1:0] res_idx;
  logic res_ev;

  // the frame count only changes with no reference in flight or arriving
  assign cfg_ready = (state == ST_IDLE) && !in_valid;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign resolve   = (state == ST_RESOLVE) && out_free;

  always_comb begin
    chain[0]             = '0;
    chain[0].valid       = accept;
    chain[0].page        = PAGE_BITS'(page_number);
  end

  for (genvar k = 0; k < NUM_FRAMES; k++) begin : g_cell
    assign live[k]    = (k == 0) || (k < int'(active_reg));
    assign tok_vld[k] = chain[k+1].valid;

    lfu_cell #(
      .NUM_FRAMES (NUM_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS),
      .IDX_BITS   (IDX_BITS),
      .CELL_INDEX (k),
      .tok_t      (tok_t),
      .upd_t      (upd_t)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .live    (live[k]),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1]),
      .upd     (upd)
    );
  end

  assign res_idx = pend.found ? pend.hit_idx : pend.best_idx;
  assign res_ev  = !pend.found && pend.best_fvalid;

  always_comb begin
    upd.en   = resolve;
    upd.hit  = pend.found;
    upd.idx  = res_idx;
    upd.page = pend.page;
  end

  always_comb begin
    fault_next = fault;
    if (!pend.found && (fault != {FB{1'b1}})) begin
      fault_next = fault + FB'(1);
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (chain[NUM_FRAMES].valid) begin
          state_next = ST_RESOLVE;
        end
      end
      ST_RESOLVE: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      active_reg <= lfu_pkg::ACTIVE_RESET;
      fault      <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        active_reg <= active_frames;
      end
      if (resolve) begin
        fault     <= fault_next;
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // token leaving the chain is parked until the result register frees up
  always_ff @(posedge clk) begin
    if ((state == ST_SEARCH) && chain[NUM_FRAMES].valid) begin
      pend <= chain[NUM_FRAMES];
    end
  end

  always_ff @(posedge clk) begin
    if (resolve) begin
      hit           <= pend.found;
      frame_index   <= lfu_pkg::INDEX_FIELD_BITS'(res_idx);
      evicted_valid <= res_ev;
      evicted_page  <= res_ev ? lfu_pkg::PAGE_FIELD_BITS'(pend.best_page) : '0;
      fault_total   <= fault_next;
    end
  end

`include "lfu_page_replacement_top_assert.svh"

  `LFU_ASSERT_CLK(a_one_token, $onehot0(tok_vld), "more than one search token in the chain")
  `LFU_ASSERT_CLK(a_token_in_search, chain[NUM_FRAMES].valid |-> (state == ST_SEARCH), "token left chain outside search")
  `LFU_ASSERT_CLK(a_update_loads_out, upd.en |=> out_valid, "write-back without a result beat")
  `LFU_ASSERT_CLK(a_fault_monotonic, 1'b1 |=> (fault >= $past(fault)), "fault total went down")

endmodule

`default_nettype wire

FILE: tb/sv/tb_top.sv
// testbench for the lfu page replacement block: directed and random runs
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NF = lfu_pkg::NUM_FRAMES_DEF;
  localparam int PW = lfu_pkg::PAGE_FIELD_BITS;
  localparam int CW = lfu_pkg::COUNT_BITS_DEF;
  localparam int IW = lfu_pkg::INDEX_FIELD_BITS;
  localparam int FW = lfu_pkg::FAULT_BITS;
  localparam int AW = lfu_pkg::ACTIVE_BITS;
  localparam int STALL_LIMIT = 4000;
  localparam int MAX_PRINTED = 40;

  typedef struct packed {
    logic          hit;
    logic [IW-1:0] idx;
    logic          ev_valid;
    logic [PW-1:0] ev_page;
    logic [FW-1:0] faults;
  } lfu_outcome_t;

  logic          clk;
  logic          rst = 1'b1;
  logic          cfg_valid = 1'b0;
  logic          cfg_ready;
  logic [AW-1:0] active_frames = lfu_pkg::ACTIVE_RESET;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [PW-1:0] page_number = '0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          hit;
  logic [IW-1:0] frame_index;
  logic          evicted_valid;
  logic [PW-1:0] evicted_page;
  logic [FW-1:0] fault_total;

  lfu_page_replacement_top i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .active_frames (active_frames),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .page_number   (page_number),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .hit           (hit),
    .frame_index   (frame_index),
    .evicted_valid (evicted_valid),
    .evicted_page  (evicted_page),
    .fault_total   (fault_total)
  );

  // shadow state of the frame table
  logic [PW-1:0] tag_page [NF];
  bit            tag_valid [NF];
  logic [CW-1:0] use_cnt [NF];
  logic [FW-1:0] fault_cnt;
  logic [AW-1:0] cfg_active;

  lfu_outcome_t awaited_outcomes[$];
  lfu_outcome_t want;
  bit steady = 1'b0;
  int mismatches = 0;
  int n_refs = 0;
  int n_hits = 0;
  int n_cfg = 0;
  int idle_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic lfu_outcome_t reference_page(input logic [PW-1:0] pg);
    lfu_outcome_t o;
    int n;
    int slot;
    bit found;
    n = (cfg_active == 0) ? 1 : (cfg_active > NF) ? NF : int'(cfg_active);
    o = '0;
    slot = 0;
    found = 1'b0;
    for (int k = 0; k < n; k++)
      if (!found && tag_valid[k] && tag_page[k] == pg) begin
        slot = k;
        found = 1'b1;
      end
    if (found) begin
      o.hit = 1'b1;
      if (use_cnt[slot] != '1) use_cnt[slot]++;
    end else begin
      // lowest count wins, strict compare keeps the lowest index on ties
      for (int k = 1; k < n; k++)
        if (use_cnt[k] < use_cnt[slot]) slot = k;
      if (tag_valid[slot]) begin
        o.ev_valid = 1'b1;
        o.ev_page = tag_page[slot];
      end
      tag_page[slot] = pg;
      tag_valid[slot] = 1'b1;
      use_cnt[slot] = 1;
      if (fault_cnt != '1) fault_cnt++;
    end
    o.idx = slot[IW-1:0];
    o.faults = fault_cnt;
    return o;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTED) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic send_page(input logic [PW-1:0] pg);
    lfu_outcome_t o;
    if (!steady && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    page_number <= pg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    o = reference_page(pg);
    awaited_outcomes.push_back(o);
    n_refs++;
    if (o.hit) n_hits++;
  endtask

  // wait until every outstanding result beat has come back
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_active(input logic [AW-1:0] v);
    settle();
    cfg_valid <= 1'b1;
    active_frames <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    cfg_active = v;
    n_cfg++;
  endtask

  // receiver side: random backpressure, none during steady stretches
  always @(posedge clk) out_stall <= !steady && ($urandom_range(99) < 37);

  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      if (awaited_outcomes.size() == 0) begin
        flag_mismatch("result beat with nothing outstanding");
      end else begin
        want = awaited_outcomes.pop_front();
        if (hit !== want.hit)
          flag_mismatch($sformatf("hit got %b want %b", hit, want.hit));
        if (frame_index !== want.idx)
          flag_mismatch($sformatf("frame_index got %0d want %0d", frame_index, want.idx));
        if (evicted_valid !== want.ev_valid)
          flag_mismatch($sformatf("evicted_valid got %b want %b",
                                  evicted_valid, want.ev_valid));
        if (evicted_page !== want.ev_page)
          flag_mismatch($sformatf("evicted_page got %h want %h",
                                  evicted_page, want.ev_page));
        if (fault_total !== want.faults)
          flag_mismatch($sformatf("fault_total got %0d want %0d", fault_total, want.faults));
      end
    end
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
      $display("lfu_page_replacement_top test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // reset value of the register, fill, hits, then lowest-count eviction
  task automatic test_fill_and_hit();
    logic [PW-1:0] pages [8] = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA,
                                 16'h0001, 16'h8000, 16'h7FFF, 16'hFFFE};
    foreach (pages[k]) send_page(pages[k]);
    send_page(16'hFFFF);
    send_page(16'h0000);
    send_page(16'h0000);
    send_page(16'h1234);
    send_page(16'h5555);
  endtask

  // zero and oversized counts, inactive frames, duplicate tags after regrowth
  task automatic test_frame_limits();
    write_active(4'd1);
    send_page(16'h00FF);
    send_page(16'h00FF);
    write_active(4'd0);
    send_page(16'hFFFF);
    write_active(4'd8);
    send_page(16'hFFFF);
    write_active(4'd15);
    send_page(16'hC3C3);
    write_active(4'd9);
    send_page(16'h3C3C);
    write_active(4'd2);
    send_page(16'h7FFF);
    write_active(4'd8);
    send_page(16'h7FFF);
  endtask

  task automatic test_random_refs();
    logic [AW-1:0] settings [10] = '{4'd8, 4'd1, 4'd3, 4'd0, 4'd15,
                                     4'd2, 4'd9, 4'd5, 4'd4, 4'd7};
    logic [PW-1:0] pool [12];
    logic [PW-1:0] corners [4] = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF};
    int r;
    foreach (settings[p]) begin
      write_active(p == 8 ? AW'($urandom_range(0, 15)) : settings[p]);
      foreach (pool[k]) pool[k] = PW'($urandom_range(0, 65535));
      steady = (p == 4);
      repeat (63) begin
        r = $urandom_range(99);
        // skewed pool picks give uneven use counts and plenty of hits
        if (r < 75) send_page(pool[$urandom_range(0, $urandom_range(0, 11))]);
        else if (r < 95) send_page(PW'($urandom_range(0, 65535)));
        else send_page(corners[$urandom_range(0, 3)]);
      end
      steady = 1'b0;
    end
  endtask

  initial begin
    foreach (tag_valid[k]) begin
      tag_page[k] = '0;
      tag_valid[k] = 1'b0;
      use_cnt[k] = '0;
    end
    fault_cnt = '0;
    cfg_active = lfu_pkg::ACTIVE_RESET;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_fill_and_hit();
    test_frame_limits();
    test_random_refs();
    settle();
    repeat (NF + 4) @(posedge clk);
    if (awaited_outcomes.size() != 0) flag_mismatch("results still outstanding at end");
    $display("covered %0d references, %0d hits, over %0d writes of the frame count",
             n_refs, n_hits, n_cfg);
    $display("frame count corners, inactive frames and duplicate tags run; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("lfu_page_replacement_top test passed");
    end else begin
      $display("lfu_page_replacement_top test failed");
    end
    $finish;
  end

endmodule
